@@ hdl/bpc_pkg.sv @@
`timescale 1ns / 1ps

package bpc_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 64;
	localparam int unsigned KEY_W           = 32;
	localparam int unsigned QUEUE_DEPTH     = 2;
	localparam logic [KEY_W-1:0] SIGN_FLIP  = {1'b1, {(KEY_W-1){1'b0}}};
	// most negative key in biased (sign-flipped) form
	localparam logic [KEY_W-1:0] BOUND_INIT = '0;

	typedef struct packed {
		logic signed [KEY_W-1:0] key_value;
		logic                    seq_last;
	} item_t;

	typedef struct packed {
		logic valid_so_far;
		logic stack_overflow;
		logic verdict_final;
	} result_t;

	typedef struct packed {
		logic             avail;
		logic [KEY_W-1:0] key;
		logic             last;
	} q_head_t;

endpackage

@@ hdl/bst_preorder_checker.sv @@
// A word lands in the input queue at the accepting edge; a key pops the stack entries smaller
// than it, then finishes once the result word is free, and its result word shows on the next cycle.
// Keys are handled one at a time from the queue head; the stack RAM gives one pop a cycle.
// Reset clears the queues, stack count, bound and flags at once; the stack RAM is not cleared.
`timescale 1ns / 1ps

module bst_preorder_checker #(
	parameter int unsigned STACK_DEPTH = bpc_pkg::STACK_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  bpc_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output bpc_pkg::result_t result
);

	bpc_pkg::q_head_t head;
	logic             deq;

	bpc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.head   (head),
		.deq    (deq)
	);

	bpc_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.deq    (deq),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

@@ hdl/bpc_ram.sv @@
`timescale 1ns / 1ps

module bpc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hdl/bpc_front.sv @@
`timescale 1ns / 1ps

module bpc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  bpc_pkg::item_t  item,
	output bpc_pkg::q_head_t head,
	input  logic            deq
);

	localparam int unsigned PW = $clog2(bpc_pkg::QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(bpc_pkg::QUEUE_DEPTH + 1);

	logic [bpc_pkg::KEY_W-1:0] key_q  [bpc_pkg::QUEUE_DEPTH];
	logic                      last_q [bpc_pkg::QUEUE_DEPTH];
	logic [PW-1:0]             wr_ptr_q;
	logic [PW-1:0]             rd_ptr_q;
	logic [CW-1:0]             cnt_q;
	logic                      do_wr;
	logic                      do_rd;

	assign full  = (cnt_q == CW'(bpc_pkg::QUEUE_DEPTH));
	assign do_wr = push && !full;
	assign do_rd = deq && (cnt_q != '0);

	assign head.avail = (cnt_q != '0);
	assign head.key   = key_q[rd_ptr_q];
	assign head.last  = last_q[rd_ptr_q];

	// bias the key so that an unsigned compare orders it as signed
	always_ff @(posedge clk) begin
		if (do_wr) begin
			key_q[wr_ptr_q]  <= item.key_value ^ bpc_pkg::SIGN_FLIP;
			last_q[wr_ptr_q] <= item.seq_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(bpc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(bpc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ hdl/bpc_back.sv @@
`timescale 1ns / 1ps

module bpc_back #(
	parameter int unsigned STACK_DEPTH = bpc_pkg::STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bpc_pkg::q_head_t  head,
	output logic              deq,
	output logic              empty,
	input  logic              pop,
	output bpc_pkg::result_t  result
);

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned KW = bpc_pkg::KEY_W;

	logic [CW-1:0]    cnt_q;
	logic [KW-1:0]    bound_q;
	logic [KW-1:0]    top_q;
	logic             from_ram_q;
	logic             failed_q;
	logic             ovf_q;
	bpc_pkg::result_t res_q;
	logic             res_valid_q;

	logic [KW-1:0] rd_data;
	logic [KW-1:0] top_eff;
	logic          below;
	logic          stack_full;
	logic          pop_go;
	logic          finish;
	logic          live;
	logic          push_go;
	logic          fail_next;
	logic          ovf_next;
	logic [AW-1:0] rd_idx;

	assign top_eff    = from_ram_q ? rd_data : top_q;
	assign below      = head.key < bound_q;
	assign stack_full = (cnt_q == CW'(STACK_DEPTH));
	assign live       = head.avail && !failed_q && !below;
	assign pop_go     = live && (cnt_q != '0) && (top_eff < head.key);
	assign finish     = head.avail && !pop_go && (!res_valid_q || pop);
	assign push_go    = finish && live && !stack_full;
	assign fail_next  = failed_q || (finish && !failed_q && (below || stack_full));
	assign ovf_next   = ovf_q || (finish && live && stack_full);
	assign rd_idx     = cnt_q[AW-1:0] - AW'(2);

	assign deq    = finish;
	assign empty  = !res_valid_q;
	assign result = res_q;

	bpc_ram #(
		.WIDTH (KW),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (push_go),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (head.key),
		.rd_en   (pop_go),
		.rd_addr (rd_idx),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (push_go) begin
			top_q <= head.key;
		end
		if (finish) begin
			res_q.valid_so_far   <= !fail_next;
			res_q.stack_overflow <= ovf_next;
			res_q.verdict_final  <= head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			bound_q     <= bpc_pkg::BOUND_INIT;
			from_ram_q  <= 1'b0;
			failed_q    <= 1'b0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop_go) begin
				bound_q    <= top_eff;
				cnt_q      <= cnt_q - 1'b1;
				from_ram_q <= 1'b1;
			end else if (finish && head.last) begin
				cnt_q      <= '0;
				bound_q    <= bpc_pkg::BOUND_INIT;
				from_ram_q <= 1'b0;
				failed_q   <= 1'b0;
				ovf_q      <= 1'b0;
			end else if (finish) begin
				failed_q <= fail_next;
				ovf_q    <= ovf_next;
				if (push_go) begin
					cnt_q      <= cnt_q + 1'b1;
					from_ram_q <= 1'b0;
				end
			end
			if (finish) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule
